### hw/rtl/b64e_pkg.sv
package b64e_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [6:0] PAD_CHAR    = 7'd61;
    localparam logic [6:0] CHAR_PLUS   = 7'd43;
    localparam logic [6:0] CHAR_SLASH  = 7'd47;
    localparam logic [6:0] UPPER_BASE  = 7'd65;
    localparam logic [6:0] LOWER_DELTA = 7'd71;
    localparam logic [6:0] DIGIT_DELTA = 7'd4;
    localparam logic [5:0] UPPER_END   = 6'd26;
    localparam logic [5:0] LOWER_END   = 6'd52;
    localparam logic [5:0] DIGIT_END   = 6'd62;
    localparam logic [5:0] CODE_PLUS   = 6'd62;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } out_item_t;

    // one byte's work: up to two sextets, then padding up to total_m1 + 1 characters
    typedef struct packed {
        logic [1:0][5:0] sx;
        logic [1:0]      nsx;
        logic [1:0]      total_m1;
        logic            last;
    } op_t;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] v7;
        logic [6:0] r;
        v7 = {1'b0, v};
        if (v < UPPER_END)
        begin
            r = UPPER_BASE + v7;
        end
        else if (v < LOWER_END)
        begin
            r = LOWER_DELTA + v7;
        end
        else if (v < DIGIT_END)
        begin
            r = v7 - DIGIT_DELTA;
        end
        else if (v == CODE_PLUS)
        begin
            r = CHAR_PLUS;
        end
        else
        begin
            r = CHAR_SLASH;
        end
        return r;
    endfunction

endpackage

### hw/rtl/b64e_front.sv
module b64e_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64e_pkg::in_item_t item,
    input  logic               full,
    output logic               wr_en,
    output b64e_pkg::op_t      op
);
    import b64e_pkg::*;

    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_MID   = 2'd1;
    localparam logic [1:0] PHASE_END   = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;
    logic [7:0] b;

    assign b     = item.data_byte;
    assign wr_en = push && !full;

    always_comb
    begin
        op         = '0;
        phase_next = PHASE_START;
        left_next  = '0;
        unique case (phase_reg)
            PHASE_MID:
            begin
                op.sx[0] = {left_reg[1:0], b[7:4]};
                if (item.last_byte)
                begin
                    op.sx[1]    = {b[3:0], 2'b00};
                    op.nsx      = 2'd2;
                    op.total_m1 = 2'd2;
                    op.last     = 1'b1;
                end
                else
                begin
                    op.nsx      = 2'd1;
                    op.total_m1 = 2'd0;
                    phase_next  = PHASE_END;
                    left_next   = b[3:0];
                end
            end
            PHASE_END:
            begin
                op.sx[0]    = {left_reg, b[7:6]};
                op.sx[1]    = b[5:0];
                op.nsx      = 2'd2;
                op.total_m1 = 2'd1;
                op.last     = item.last_byte;
            end
            default:
            begin
                op.sx[0] = b[7:2];
                if (item.last_byte)
                begin
                    op.sx[1]    = {b[1:0], 4'b0000};
                    op.nsx      = 2'd2;
                    op.total_m1 = 2'd3;
                    op.last     = 1'b1;
                end
                else
                begin
                    op.nsx      = 2'd1;
                    op.total_m1 = 2'd0;
                    phase_next  = PHASE_MID;
                    left_next   = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_START;
            left_reg  <= '0;
        end
        else if (wr_en)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

### hw/rtl/b64e_queue.sv
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  b64e_pkg::op_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output b64e_pkg::op_t rd_data
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_t              slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

### hw/rtl/b64e_back.sv
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  b64e_pkg::op_t       q_data,
    output logic                q_rd,
    output logic                empty,
    input  logic                pop,
    output b64e_pkg::out_item_t result
);
    import b64e_pkg::*;

    op_t        cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    out_item_t  out_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       at_end;
    logic       load;
    out_item_t  gen;

    assign advance = cur_valid_reg && (!out_valid_reg || pop);
    assign at_end  = (idx_reg == cur_reg.total_m1);
    assign load    = q_valid && (!cur_valid_reg || (advance && at_end));
    assign q_rd    = load;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        gen.out_char = (idx_reg < cur_reg.nsx) ? b64_char(cur_reg.sx[idx_reg[0]]) : PAD_CHAR;
        gen.out_last = cur_reg.last && at_end;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_data;
        end
        if (advance)
        begin
            out_reg <= gen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (advance && at_end)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg <= cur_reg.total_m1)
        else $error("character index past end of op");

    a_has_sextet: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.nsx != 2'd0)
                          && (3'(cur_reg.nsx) <= 3'(cur_reg.total_m1) + 3'd1))
        else $error("op with bad sextet count");

    a_gen_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("generated character lost");

endmodule

### hw/rtl/base64_stream_encoder.sv
// Standard base64 encoder for a byte stream. One byte is taken per transfer, with
// last_byte marking the end of a message; characters come out one per transfer, the
// final one of each message (after any '=' padding) flagged by out_last. The input
// side takes a byte every cycle while the op queue has room; the character sequencer
// emits one character per cycle while an op is held and the result is free or popped;
// three bytes make four characters, so the single-character result port sets the
// sustained byte rate. Each op is registered in the queue, then in the current-op register.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64e_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output b64e_pkg::out_item_t result
);
    import b64e_pkg::*;

    logic wr_en;
    op_t  wr_op;
    logic q_rd;
    logic q_valid;
    op_t  q_data;

    b64e_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .wr_en (wr_en),
        .op    (wr_op)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_op),
        .full     (full),
        .rd_en    (q_rd),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    b64e_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
